// ===== rtl/slq_pkg.sv =====
package slq_pkg;

  // Default list depth.
  localparam int SLQ_CAPACITY = 16;

  // Request codes.
  typedef enum logic [2:0] {
    OP_FRONT   = 3'd0,
    OP_END     = 3'd1,
    OP_SORTED  = 3'd2,
    OP_DEQUEUE = 3'd3,
    OP_QUERY   = 3'd4
  } op_t;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } st_t;

  // Controller states.
  typedef enum logic [1:0] {
    S_IDLE,
    S_CMP,
    S_APPLY
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic cmp;
    logic apply;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_busy;
  } stat_t;

endpackage

// ===== rtl/slq_ctrl.sv =====
module slq_ctrl import slq_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   in_valid,
  output logic   in_stall,
  input  stat_t  stat,
  output cmd_t   cmd
);

  state_t state_r, state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    unique case (state_r)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_CMP;
        end
      end
      S_CMP: begin
        cmd.cmp   = 1'b1;
        state_nxt = S_APPLY;
      end
      S_APPLY: begin
        // Wait until the output register can take the result beat.
        if (!stat.out_busy) begin
          cmd.apply = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/slq_datapath.sv =====
module slq_datapath import slq_pkg::*; #(
  parameter int CAPACITY = SLQ_CAPACITY
) (
  input  logic        clk,
  input  logic        rst_n,
  input  cmd_t        cmd,
  output stat_t       stat,
  input  logic [2:0]  in_req_type,
  input  logic [31:0] in_value,
  input  logic        out_stall,
  output logic        out_valid,
  output logic        out_found,
  output logic [31:0] out_head_value,
  output logic        out_head_valid,
  output logic [4:0]  out_entry_count,
  output logic [1:0]  out_status
);

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int LVL   = $clog2(CAPACITY);

  logic [2:0]          req_r;
  logic [31:0]         val_r;
  logic [31:0]         entries_r [CAPACITY];
  logic [CAPACITY-1:0] lt_r, eq_r;
  logic [CAPACITY-1:0] ge;
  logic [CAPACITY-1:0] pre [LVL+1];
  logic [CAPACITY-1:0] shift;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic [CNT_W+4:0]    cnt_ext;
  logic                is_ins, full, empty, ins_ok, deq_ok;
  logic [31:0]         head_nxt;
  logic [1:0]          status_nxt;
  logic                out_valid_r;
  logic                found_r, head_valid_r;
  logic [31:0]         head_value_r;
  logic [4:0]          entry_count_r;
  logic [1:0]          status_r;

  // Request latch.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r <= in_req_type;
      val_r <= in_value;
    end
  end

  // Request decode against the current fill level.
  always_comb begin
    is_ins = (req_r == OP_FRONT) || (req_r == OP_END) || (req_r == OP_SORTED);
    full   = (count_r == CNT_W'(CAPACITY));
    empty  = (count_r == '0);
    ins_ok = cmd.apply && is_ins && !full;
    deq_ok = cmd.apply && (req_r == OP_DEQUEUE) && !empty;
  end

  // Row of cells: compare flags, insert point and shift moves.
  for (genvar j = 0; j < CAPACITY; j++) begin : g_cell
    logic        above;
    logic [31:0] from_prev, from_next;

    assign above = (count_r <= CNT_W'(j));

    // On a sorted add the first cell not smaller, or free, takes the new value.
    always_comb begin
      unique case (req_r)
        OP_FRONT:  ge[j] = 1'b1;
        OP_END:    ge[j] = above;
        OP_SORTED: ge[j] = !lt_r[j] || above;
        default:   ge[j] = 1'b0;
      endcase
    end

    if (j == 0) begin : g_first
      assign from_prev = val_r;
    end else begin : g_mid
      assign from_prev = entries_r[j-1];
    end
    if (j == CAPACITY - 1) begin : g_last
      assign from_next = entries_r[j];
    end else begin : g_inner
      assign from_next = entries_r[j+1];
    end

    // Registered compares against the request value.
    always_ff @(posedge clk) begin
      if (cmd.cmp) begin
        lt_r[j] <= ($signed(entries_r[j]) < $signed(val_r));
        eq_r[j] <= (entries_r[j] == val_r) && !above;
      end
    end

    // Entry storage: shift toward the tail on insert, toward the head on dequeue.
    always_ff @(posedge clk) begin
      if (ins_ok) begin
        if (shift[j]) begin
          entries_r[j] <= from_prev;
        end else if (ge[j]) begin
          entries_r[j] <= val_r;
        end
      end else if (deq_ok) begin
        entries_r[j] <= from_next;
      end
    end
  end

  // Cells past the insert point shift: prefix OR of the flags below each cell.
  assign pre[0] = {ge[CAPACITY-2:0], 1'b0};
  for (genvar l = 0; l < LVL; l++) begin : g_lvl
    for (genvar j = 0; j < CAPACITY; j++) begin : g_bit
      if (j >= (1 << l)) begin : g_or
        assign pre[l+1][j] = pre[l][j] | pre[l][j-(1 << l)];
      end else begin : g_pass
        assign pre[l+1][j] = pre[l][j];
      end
    end
  end
  assign shift = pre[LVL];

  // Fill level, head and status after the operation.
  always_comb begin
    count_nxt = count_r;
    if (ins_ok) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (deq_ok) begin
      count_nxt = count_r - CNT_W'(1);
    end

    head_nxt = entries_r[0];
    if (ins_ok) begin
      head_nxt = ge[0] ? val_r : entries_r[0];
    end else if (deq_ok) begin
      head_nxt = entries_r[1];
    end

    priority if (is_ins && full) begin
      status_nxt = ST_FULL;
    end else if ((req_r == OP_DEQUEUE) && empty) begin
      status_nxt = ST_EMPTY;
    end else begin
      status_nxt = ST_DONE;
    end

    cnt_ext = {5'b0, count_nxt};
  end

  // Fill counter.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.apply) begin
      count_r <= count_nxt;
    end
  end

  // Output register: holds a result beat until it is taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.apply) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.apply) begin
      found_r       <= (req_r == OP_QUERY) && (|eq_r);
      head_valid_r  <= (count_nxt != '0);
      head_value_r  <= (count_nxt != '0) ? head_nxt : 32'd0;
      entry_count_r <= cnt_ext[4:0];
      status_r      <= status_nxt;
    end
  end

  assign stat.out_busy   = out_valid_r && out_stall;
  assign out_valid       = out_valid_r;
  assign out_found       = found_r;
  assign out_head_value  = head_value_r;
  assign out_head_valid  = head_valid_r;
  assign out_entry_count = entry_count_r;
  assign out_status      = status_r;

endmodule

// ===== rtl/sorted_insert_list_queue_unit.sv =====
// Sorted list queue of up to CAPACITY signed 32-bit values, head at position
// zero. Each request beat (add front, add end, sorted add, dequeue, or
// membership query) produces one result beat with the head value, head valid,
// entry count, found flag and status. Each item is first latched, then every
// cell registers its compare against the value, and then the cell row shifts
// or writes in parallel and the result is loaded into the output register.
// The apply step waits while the output register still holds a stalled beat;
// a new request is taken as soon as the previous one has been applied. Entry
// storage is not cleared by reset; the fill count, the output valid flag and
// the controller state are.
module sorted_insert_list_queue_unit import slq_pkg::*; #(
  parameter int CAPACITY = SLQ_CAPACITY
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_req_type,
  input  logic [31:0] in_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_found,
  output logic [31:0] out_head_value,
  output logic        out_head_valid,
  output logic [4:0]  out_entry_count,
  output logic [1:0]  out_status
);

  cmd_t  cmd;
  stat_t stat;

  // Sequencer.
  slq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Cell row, counter and output register.
  slq_datapath #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .in_req_type     (in_req_type),
    .in_value        (in_value),
    .out_stall       (out_stall),
    .out_valid       (out_valid),
    .out_found       (out_found),
    .out_head_value  (out_head_value),
    .out_head_valid  (out_head_valid),
    .out_entry_count (out_entry_count),
    .out_status      (out_status)
  );

endmodule

// ===== rtl/slq_checker.sv =====
module slq_checker import slq_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic        out_found,
  input logic [31:0] out_head_value,
  input logic        out_head_valid,
  input logic [1:0]  out_status
);

  // A stalled result beat stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result beat dropped while stalled");

  // The block is busy in the cycle after it takes a request beat.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("request taken while previous one in progress");

  // An empty list reports a zero head.
  a_empty_head: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_head_valid |-> out_head_value == 32'd0)
    else $error("nonzero head on empty list");

  // Found is only reported for a completed query.
  a_found_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_found |-> out_status == ST_DONE)
    else $error("found set with error status");

  // An empty list cannot report a rejected insert.
  a_full_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_FULL |-> out_head_valid)
    else $error("full status with empty list");

endmodule

bind sorted_insert_list_queue_unit slq_checker u_chk (.*);

// ===== tb/sv/sorted_insert_list_queue_unit_tb.sv =====
module sorted_insert_list_queue_unit_tb;
  import slq_pkg::*;

  localparam int CAP = SLQ_CAPACITY;
  localparam int RANDOM_ITEMS = 1120;
  localparam int DRAIN_CYCLES = 20;

  // Request codes that the block must ignore.
  localparam logic [2:0] OP_RSVD_FIRST = 3'd5;
  localparam logic [2:0] OP_RSVD_LAST = 3'd7;

  // Traffic shapes for the random part and receiver stall patterns.
  typedef enum int {MIX_FILL, MIX_DRAIN, MIX_BALANCED, MIX_LOOKUP} mix_t;
  typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_pat_t;

  typedef struct {
    logic        found;
    logic [31:0] head_value;
    logic        head_valid;
    logic [4:0]  entry_count;
    logic [1:0]  status;
  } list_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [2:0]  in_req_type = 3'd0;
  logic [31:0] in_value = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_found;
  logic [31:0] out_head_value;
  logic        out_head_valid;
  logic [4:0]  out_entry_count;
  logic [1:0]  out_status;

  // Mirror of the list contents, head at index zero.
  logic signed [31:0] held_vals[$];
  // Results predicted for accepted requests, oldest first.
  list_result_t pending_results[$];
  int err_count = 0;
  int burst_left = 0;

  stall_pat_t stall_mode = STALL_NONE;
  int stall_left = 0;
  int cyc = 0;

  always #6 clk = ~clk;

  sorted_insert_list_queue_unit u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_req_type    (in_req_type),
    .in_value       (in_value),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_found      (out_found),
    .out_head_value (out_head_value),
    .out_head_valid (out_head_valid),
    .out_entry_count(out_entry_count),
    .out_status     (out_status)
  );

  // Apply one request to the mirrored list and queue the result it should give.
  function automatic void apply_request(logic [2:0] op, logic signed [31:0] val);
    list_result_t res;
    int pos;
    res.found = 1'b0;
    res.status = ST_DONE;
    case (op)
      OP_FRONT, OP_END, OP_SORTED: begin
        if (held_vals.size() >= CAP) begin
          res.status = ST_FULL;
        end else if (op == OP_FRONT) begin
          held_vals.push_front(val);
        end else if (op == OP_END) begin
          held_vals.push_back(val);
        end else begin
          // Goes before the first entry that is not smaller.
          pos = 0;
          while (pos < held_vals.size() && held_vals[pos] < val) pos++;
          held_vals.insert(pos, val);
        end
      end
      OP_DEQUEUE: begin
        if (held_vals.size() == 0) begin
          res.status = ST_EMPTY;
        end else begin
          void'(held_vals.pop_front());
        end
      end
      OP_QUERY: begin
        foreach (held_vals[k]) begin
          if (held_vals[k] == val) res.found = 1'b1;
        end
      end
      default: begin
      end
    endcase
    res.head_valid = (held_vals.size() > 0);
    res.head_value = '0;
    if (res.head_valid) res.head_value = held_vals[0];
    res.entry_count = 5'(held_vals.size());
    pending_results.push_back(res);
  endfunction

  function automatic void check_field(string field, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0h, got %0h", field, want, got);
      err_count++;
    end
  endfunction

  // Send one request beat, idling between bursts, and predict it on acceptance.
  task automatic send_item(logic [2:0] op, logic [31:0] val);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 150) :
                                                 $urandom_range(1, 12);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_req_type <= op;
    in_value <= val;
    do @(posedge clk); while (in_stall);
    apply_request(op, val);
  endtask

  // Compare every accepted result beat with the oldest prediction.
  always @(posedge clk) begin : result_check
    list_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("result beat with no request pending");
        err_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("found", 32'(want.found), 32'(out_found));
        check_field("head_value", want.head_value, out_head_value);
        check_field("head_valid", 32'(want.head_valid), 32'(out_head_valid));
        check_field("entry_count", 32'(want.entry_count), 32'(out_entry_count));
        check_field("status", 32'(want.status), 32'(out_status));
      end
    end
  end

  // The receiver switches between randomly chosen stall patterns.
  always @(posedge clk) begin
    cyc++;
    if (stall_left == 0) begin
      stall_mode = stall_pat_t'($urandom_range(0, 3));
      stall_left = $urandom_range(20, 200);
    end
    stall_left--;
    case (stall_mode)
      STALL_NONE: out_stall <= 1'b0;
      STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
      STALL_HEAVY: out_stall <= ($urandom_range(0, 9) < 7);
      default: out_stall <= ((cyc % 5) < 2);
    endcase
  end

  function automatic logic [2:0] pick_op(mix_t mix);
    int roll;
    int ins_pct;
    int deq_pct;
    case (mix)
      MIX_FILL: begin
        ins_pct = 70;
        deq_pct = 15;
      end
      MIX_DRAIN: begin
        ins_pct = 15;
        deq_pct = 70;
      end
      MIX_BALANCED: begin
        ins_pct = 40;
        deq_pct = 35;
      end
      default: begin
        ins_pct = 25;
        deq_pct = 20;
      end
    endcase
    // A few requests carry an unused code.
    if ($urandom_range(0, 99) < 4) return 3'($urandom_range(OP_RSVD_FIRST, OP_RSVD_LAST));
    roll = $urandom_range(0, 99);
    if (roll < ins_pct) begin
      case ($urandom_range(0, 3))
        0: return OP_FRONT;
        1: return OP_END;
        default: return OP_SORTED;
      endcase
    end
    if (roll < ins_pct + deq_pct) return OP_DEQUEUE;
    return OP_QUERY;
  endfunction

  // Values lean toward stored ones, small ones and the extremes so that
  // duplicates, query hits and sign boundaries show up often.
  function automatic logic [31:0] pick_value();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 25 && held_vals.size() > 0) begin
      return held_vals[$urandom_range(0, held_vals.size() - 1)];
    end
    if (roll < 45) return $urandom_range(0, 8) - 4;
    if (roll < 53) begin
      case ($urandom_range(0, 3))
        0: return 32'h8000_0000;
        1: return 32'h7fff_ffff;
        2: return 32'h0000_0000;
        default: return 32'hffff_ffff;
      endcase
    end
    return $urandom();
  endfunction

  // Requests on an empty list, including codes that must be ignored.
  task automatic test_empty_list();
    send_item(OP_QUERY, 32'h0000_0000);
    send_item(OP_DEQUEUE, 32'hdead_beef);
    send_item(OP_RSVD_FIRST, 32'h1234_5678);
    send_item(OP_RSVD_LAST, 32'hffff_ffff);
  endtask

  // Sorted adds at the signed extremes, a duplicate, front and end adds,
  // a query hit and miss, and a dequeue.
  task automatic test_extremes_and_order();
    send_item(OP_SORTED, 32'h7fff_ffff);
    send_item(OP_SORTED, 32'h8000_0000);
    send_item(OP_SORTED, 32'h0000_0000);
    send_item(OP_SORTED, 32'hffff_ffff);
    send_item(OP_SORTED, 32'hffff_ffff);
    send_item(OP_FRONT, 32'h0000_0001);
    send_item(OP_END, 32'hffff_fffe);
    send_item(OP_QUERY, 32'h8000_0000);
    send_item(OP_QUERY, 32'h0000_0005);
    send_item(OP_DEQUEUE, 32'h0000_0000);
  endtask

  // Fill the list, then try every kind of add, a query and an unused code while it is full.
  task automatic test_full_list();
    while (held_vals.size() < CAP) send_item(OP_SORTED, $urandom());
    send_item(OP_FRONT, 32'h5555_5555);
    send_item(OP_END, 32'haaaa_aaaa);
    send_item(OP_SORTED, 32'h8000_0000);
    send_item(OP_QUERY, held_vals[CAP - 1]);
    send_item(OP_RSVD_LAST, 32'h0000_0001);
  endtask

  // Phases that fill, drain, mix or mostly search the list.
  task automatic test_random_traffic(int n_items);
    mix_t mix;
    int phase_left;
    mix = MIX_BALANCED;
    phase_left = 0;
    for (int sent = 0; sent < n_items; sent++) begin
      if (phase_left == 0) begin
        mix = mix_t'($urandom_range(0, 3));
        phase_left = $urandom_range(10, 60);
      end
      phase_left--;
      send_item(pick_op(mix), pick_value());
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_empty_list();
    test_extremes_and_order();
    test_full_list();
    test_random_traffic(RANDOM_ITEMS);
    in_valid <= 1'b0;
    // Wait for the last result beats, then keep watching for stray ones.
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("Verification failed");
    $finish;
  end

endmodule
